/* rtl/crmw_pkg.sv */
// ----------------------------------------------------------------------------
// crmw_pkg
// Shared types and codes for the cache range maintenance walker.
// ----------------------------------------------------------------------------
package crmw_pkg;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned Q_DEPTH = 2;

   localparam logic REQ_START = 1'b0;
   localparam logic REQ_NEXT  = 1'b1;

   localparam logic [1:0] KIND_INV   = 2'd0;
   localparam logic [1:0] KIND_CLEAN = 2'd1;
   localparam logic [1:0] KIND_FLUSH = 2'd2;

   localparam logic [2:0] OP_NONE  = 3'd0;
   localparam logic [2:0] OP_CLEAN = 3'd1;
   localparam logic [2:0] OP_INV   = 3'd2;
   localparam logic [2:0] OP_CINV  = 3'd3;
   localparam logic [2:0] OP_SYNC  = 3'd4;

   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_HEAD = 4'b0010,
      PH_TAIL = 4'b0100,
      PH_WALK = 4'b1000
   } crmw_phase_type;

   // classification of one request beat
   typedef struct packed {
      logic       is_start;
      logic [1:0] kind;
      logic       start_partial;
      logic       end_partial;
   } crmw_cls_type;

   typedef struct packed {
      logic [2:0]        op_code;
      logic [DATA_W-1:0] line_addr;
      logic              last;
      logic              busy_res;
      logic              rejected;
   } crmw_rsp_type;

endpackage

/* rtl/crmw_front.sv */
// ----------------------------------------------------------------------------
// crmw_front
// Request intake: decodes the beat, aligns the range and pushes it to the queue.
// ----------------------------------------------------------------------------
module crmw_front
   import crmw_pkg::*;
#(
   parameter int unsigned LINE_BYTES = 32,
   parameter int unsigned ADDR_BITS  = 32
) (
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_type,
   input  logic [1:0]            req_range_kind,
   input  logic [DATA_W-1:0]     req_start_addr,
   input  logic [DATA_W-1:0]     req_end_addr,
   input  logic                  q_full,
   output logic                  q_push,
   output crmw_cls_type          q_cls,
   output logic [ADDR_BITS-1:0]  q_start_line,
   output logic [ADDR_BITS-1:0]  q_end_val
);

   localparam int unsigned LOFF = $clog2(LINE_BYTES);

   logic [63:0]          s_wide;
   logic [63:0]          e_wide;
   logic [ADDR_BITS-1:0] s_addr;
   logic [ADDR_BITS-1:0] e_addr;
   logic [ADDR_BITS-1:0] e_line;
   logic [1:0]           kind;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   assign s_wide = {{(64-DATA_W){1'b0}}, req_start_addr};
   assign e_wide = {{(64-DATA_W){1'b0}}, req_end_addr};
   assign s_addr = s_wide[ADDR_BITS-1:0];
   assign e_addr = e_wide[ADDR_BITS-1:0];
   assign e_line = {e_addr[ADDR_BITS-1:LOFF], {LOFF{1'b0}}};

   // kind three behaves as flush
   always_comb begin
      case (req_range_kind)
         KIND_INV:   kind = KIND_INV;
         KIND_CLEAN: kind = KIND_CLEAN;
         default:    kind = KIND_FLUSH;
      endcase
   end

   assign q_cls.is_start      = (req_type == REQ_START);
   assign q_cls.kind          = kind;
   assign q_cls.start_partial = |s_addr[LOFF-1:0];
   assign q_cls.end_partial   = |e_addr[LOFF-1:0];
   assign q_start_line        = {s_addr[ADDR_BITS-1:LOFF], {LOFF{1'b0}}};
   assign q_end_val           = (kind == KIND_INV) ? e_line : e_addr;

endmodule

/* rtl/crmw_queue.sv */
// ----------------------------------------------------------------------------
// crmw_queue
// Short FIFO between request intake and the walker.
// ----------------------------------------------------------------------------
module crmw_queue
   import crmw_pkg::*;
#(
   parameter int unsigned WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             not_empty,
   output logic             full,
   output logic [WIDTH-1:0] pop_data
);

   localparam int unsigned PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int unsigned CW = $clog2(Q_DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [Q_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CW'(Q_DEPTH));
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/crmw_back.sv */
// ----------------------------------------------------------------------------
// crmw_back
// Walker: runs the range state machine, one queued beat per cycle while the
// response side does not stall, into a registered response stage.
// ----------------------------------------------------------------------------
module crmw_back
   import crmw_pkg::*;
#(
   parameter int unsigned LINE_BYTES = 32,
   parameter int unsigned ADDR_BITS  = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  errata_split,
   input  logic                  q_not_empty,
   output logic                  q_pop,
   input  crmw_cls_type          q_cls,
   input  logic [ADDR_BITS-1:0]  q_start_line,
   input  logic [ADDR_BITS-1:0]  q_end_val,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output crmw_rsp_type          rsp_data
);

   crmw_phase_type       phase_ff, phase_in;
   logic [1:0]           kind_ff, kind_in;
   logic [ADDR_BITS-1:0] cur_ff, cur_in;
   logic [ADDR_BITS-1:0] end_ff, end_in;
   logic                 eep_ff, eep_in;
   logic                 sh_ff, sh_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   crmw_rsp_type         rsp_ff, rsp_in;

   logic [ADDR_BITS:0]   sum;
   logic [ADDR_BITS-1:0] adv;
   logic [2:0]           cinv_op;
   logic                 cinv_done;
   logic                 cinv_sh;
   logic [ADDR_BITS-1:0] addr;
   logic [63:0]          addr_wide;

   assign q_pop     = q_not_empty && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // next line, saturating to the range end past the top
   assign sum = {1'b0, cur_ff} + (ADDR_BITS+1)'(LINE_BYTES);
   assign adv = sum[ADDR_BITS] ? end_ff : sum[ADDR_BITS-1:0];

   always_comb begin
      if (sh_ff) begin
         cinv_op   = OP_INV;
         cinv_done = 1'b1;
         cinv_sh   = 1'b0;
      end else if (errata_split) begin
         cinv_op   = OP_CLEAN;
         cinv_done = 1'b0;
         cinv_sh   = 1'b1;
      end else begin
         cinv_op   = OP_CINV;
         cinv_done = 1'b1;
         cinv_sh   = 1'b0;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      kind_in  = kind_ff;
      cur_in   = cur_ff;
      end_in   = end_ff;
      eep_in   = eep_ff;
      sh_in    = sh_ff;
      addr     = '0;
      rsp_in   = '0;
      rsp_in.op_code = OP_NONE;
      if (q_cls.is_start) begin
         if (phase_ff != PH_IDLE) begin
            rsp_in.rejected = 1'b1;
         end else begin
            kind_in = q_cls.kind;
            sh_in   = 1'b0;
            cur_in  = q_start_line;
            end_in  = q_end_val;
            if (q_cls.kind == KIND_INV) begin
               eep_in = q_cls.end_partial;
               if (q_cls.start_partial) begin
                  phase_in = PH_HEAD;
               end else begin
                  phase_in = q_cls.end_partial ? PH_TAIL : PH_WALK;
               end
            end else begin
               eep_in   = 1'b0;
               phase_in = PH_WALK;
            end
         end
      end else begin
         case (phase_ff)
            PH_HEAD: begin
               addr           = cur_ff;
               rsp_in.op_code = cinv_op;
               sh_in          = cinv_sh;
               if (cinv_done) begin
                  cur_in   = adv;
                  phase_in = eep_ff ? PH_TAIL : PH_WALK;
               end
            end
            PH_TAIL: begin
               addr           = end_ff;
               rsp_in.op_code = cinv_op;
               sh_in          = cinv_sh;
               if (cinv_done) begin
                  eep_in   = 1'b0;
                  phase_in = PH_WALK;
               end
            end
            PH_WALK: begin
               if (cur_ff < end_ff) begin
                  addr = cur_ff;
                  case (kind_ff)
                     KIND_INV: begin
                        rsp_in.op_code = OP_INV;
                        cur_in         = adv;
                     end
                     KIND_CLEAN: begin
                        rsp_in.op_code = OP_CLEAN;
                        cur_in         = adv;
                     end
                     default: begin
                        rsp_in.op_code = cinv_op;
                        sh_in          = cinv_sh;
                        if (cinv_done) begin
                           cur_in = adv;
                        end
                     end
                  endcase
               end else begin
                  rsp_in.op_code = OP_SYNC;
                  rsp_in.last    = 1'b1;
                  sh_in          = 1'b0;
                  phase_in       = PH_IDLE;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
      addr_wide        = 64'(addr);
      rsp_in.line_addr = addr_wide[DATA_W-1:0];
      rsp_in.busy_res  = (phase_in != PH_IDLE);
   end

   always_comb begin
      if (q_pop) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         kind_ff      <= KIND_INV;
         cur_ff       <= '0;
         end_ff       <= '0;
         eep_ff       <= 1'b0;
         sh_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            phase_ff <= phase_in;
            kind_ff  <= kind_in;
            cur_ff   <= cur_in;
            end_ff   <= end_in;
            eep_ff   <= eep_in;
            sh_ff    <= sh_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

/* rtl/cache_range_maintenance_walker.sv */
// An accepted request beat is written to a queue entry, then to the registered response stage.
// Throughput: one request beat per cycle while the response side does not stall; every beat yields one response beat.
// The walker state update (one line add and one compare) sets this beat rate.
// A two-entry queue absorbs request beats while the response side stalls.
// Reset (synchronous) clears the queue, walker state and errata_split at once.
// ----------------------------------------------------------------------------
// cache_range_maintenance_walker
// Turns invalidate, clean and flush address ranges into per-line operations.
// ----------------------------------------------------------------------------
module cache_range_maintenance_walker
   import crmw_pkg::*;
#(
   parameter int unsigned LINE_BYTES = 32,
   parameter int unsigned ADDR_BITS  = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_type,
   input  logic [1:0]        req_range_kind,
   input  logic [DATA_W-1:0] req_start_addr,
   input  logic [DATA_W-1:0] req_end_addr,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_op_code,
   output logic [DATA_W-1:0] rsp_line_addr,
   output logic              rsp_last,
   output logic              rsp_busy_res,
   output logic              rsp_rejected,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_errata_split
);

   localparam int unsigned QW = $bits(crmw_cls_type) + 2 * ADDR_BITS;

   logic                 errata_ff;
   logic                 push;
   logic                 q_full;
   logic                 q_not_empty;
   logic                 q_pop;
   crmw_cls_type         f_cls;
   logic [ADDR_BITS-1:0] f_start_line;
   logic [ADDR_BITS-1:0] f_end_val;
   logic [QW-1:0]        q_in;
   logic [QW-1:0]        q_out;
   crmw_cls_type         b_cls;
   logic [ADDR_BITS-1:0] b_start_line;
   logic [ADDR_BITS-1:0] b_end_val;
   crmw_rsp_type         rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         errata_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         errata_ff <= csr_errata_split;
      end
   end

   crmw_front #(
      .LINE_BYTES (LINE_BYTES),
      .ADDR_BITS  (ADDR_BITS)
   ) u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_range_kind (req_range_kind),
      .req_start_addr (req_start_addr),
      .req_end_addr   (req_end_addr),
      .q_full         (q_full),
      .q_push         (push),
      .q_cls          (f_cls),
      .q_start_line   (f_start_line),
      .q_end_val      (f_end_val)
   );

   assign q_in = {f_cls, f_start_line, f_end_val};

   crmw_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (q_in),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .full      (q_full),
      .pop_data  (q_out)
   );

   assign {b_cls, b_start_line, b_end_val} = q_out;

   crmw_back #(
      .LINE_BYTES (LINE_BYTES),
      .ADDR_BITS  (ADDR_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .errata_split (errata_ff),
      .q_not_empty  (q_not_empty),
      .q_pop        (q_pop),
      .q_cls        (b_cls),
      .q_start_line (b_start_line),
      .q_end_val    (b_end_val),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp)
   );

   assign rsp_op_code   = rsp.op_code;
   assign rsp_line_addr = rsp.line_addr;
   assign rsp_last      = rsp.last;
   assign rsp_busy_res  = rsp.busy_res;
   assign rsp_rejected  = rsp.rejected;

endmodule

/* rtl/crmw_checker.sv */
// ----------------------------------------------------------------------------
// crmw_checker
// Port-level checks on the walker's response stream.
// ----------------------------------------------------------------------------
module crmw_checker
   import crmw_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [2:0]        rsp_op_code,
   input logic [DATA_W-1:0] rsp_line_addr,
   input logic              rsp_last,
   input logic              rsp_busy_res,
   input logic              rsp_rejected
);

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_op_code)
         && $stable(rsp_line_addr) && $stable(rsp_last))
      else $error("response beat changed while stalled");

   a_last_sync: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_op_code == OP_SYNC && !rsp_busy_res
         && !rsp_rejected)
      else $error("last beat is not a closing sync");

   a_sync_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_op_code == OP_SYNC |-> rsp_last && rsp_line_addr == '0)
      else $error("sync without last or with an address");

   a_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> rsp_busy_res && rsp_op_code == OP_NONE
         && rsp_line_addr == '0)
      else $error("rejected start carries an operation");

endmodule

bind cache_range_maintenance_walker crmw_checker u_crmw_checker (.*);
